### sv/sv39tw_pkg.sv
package sv39tw_pkg;

	// Sizes fixed by the item format
	localparam int VA_W      = 39;
	localparam int EADDR_W   = 15;
	localparam int ENTRY_W   = 64;
	localparam int PPN_W     = 44;
	localparam int PA_W      = 56;
	localparam int IDX_W     = 9;
	localparam int ROOT_W    = 6;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 44;

	// Default table size in pages of 512 entries
	localparam int TABLE_PAGES_DEF = 64;

	// Entry bit positions
	localparam int PTE_V_BIT   = 0;
	localparam int PTE_U_BIT   = 4;
	localparam int PTE_PPN_LSB = 10;

	// Item actions
	localparam logic ACT_WRITE     = 1'b0;
	localparam logic ACT_TRANSLATE = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_VALID = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_USER  = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE   = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_TABLE_PAGE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE_PPN  = 2'd1;

	typedef enum logic [2:0] {
		WS_IDLE,
		WS_ROOT_FAULT,
		WS_L2,
		WS_L1,
		WS_L0
	} walk_state_t;

endpackage

### sv/sv39_translate_walk_unit.sv
// Sv39-style three-level walker over an internal table memory.
// A translate issues its root read in the accept cycle, steps through L2, L1 and L0 and
// then registers its result (a bad root page via ROOT_FAULT, a pointer fault from L2/L1).
// Items are taken only in IDLE, so walks run one at a time, with three dependent reads on
// the table RAM's one read port. Reset (arst_n, async low) clears the sequencer, output
// valid and both config registers; table contents are undefined until written.
module sv39_translate_walk_unit #(
	parameter int TABLE_PAGES = sv39tw_pkg::TABLE_PAGES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item input
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [sv39tw_pkg::VA_W-1:0]          virt_addr,
	input  logic [sv39tw_pkg::EADDR_W-1:0]       entry_addr,
	input  logic [sv39tw_pkg::ENTRY_W-1:0]       entry_value,
	// result output
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [sv39tw_pkg::STATUS_W-1:0]      status,
	output logic [sv39tw_pkg::PA_W-1:0]          phys_addr,
	// config write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sv39tw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sv39tw_pkg::CFG_W-1:0]         cfg_data
);

	// Page number width; at least one bit even for a single page.
	localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
	localparam int ADDR_W = PAGE_W + sv39tw_pkg::IDX_W;
	localparam int DEPTH  = TABLE_PAGES * (2 ** sv39tw_pkg::IDX_W);

	localparam int IDX_W = sv39tw_pkg::IDX_W;
	localparam int PPN_W = sv39tw_pkg::PPN_W;

	// ---------------------------------------------------------------
	// Config registers. Always ready; unknown indexes are dropped.
	// ---------------------------------------------------------------
	logic [sv39tw_pkg::ROOT_W-1:0] root_page_q;
	logic [PPN_W-1:0]              base_ppn_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_page_q <= '0;
			base_ppn_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sv39tw_pkg::REG_ROOT_TABLE_PAGE: root_page_q <= cfg_data[sv39tw_pkg::ROOT_W-1:0];
				sv39tw_pkg::REG_TABLE_BASE_PPN:  base_ppn_q  <= cfg_data[PPN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Table RAM: one write port for entry stores, one registered read
	// port shared by the three walk levels.
	// ---------------------------------------------------------------
	logic                               wr_en;
	logic [ADDR_W-1:0]                  wr_addr;
	logic                               rd_en;
	logic [ADDR_W-1:0]                  rd_addr;
	logic [sv39tw_pkg::ENTRY_W-1:0]     rd_data;

	sv39tw_ram #(
		.WIDTH  (sv39tw_pkg::ENTRY_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (entry_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Write address: page field must lie inside the table.
	logic [31:0] wpage_ext;
	logic        wpage_ok;
	assign wpage_ext = 32'(entry_addr[sv39tw_pkg::EADDR_W-1:IDX_W]);
	assign wpage_ok  = wpage_ext < 32'(TABLE_PAGES);
	assign wr_addr   = {wpage_ext[PAGE_W-1:0], entry_addr[IDX_W-1:0]};

	// Root page check.
	logic [31:0] root_ext;
	logic        root_ok;
	assign root_ext = 32'(root_page_q);
	assign root_ok  = root_ext < 32'(TABLE_PAGES);

	// ---------------------------------------------------------------
	// Entry decode on the read data: valid, user, and the pointer
	// window check (one 45-bit subtract plus a compare).
	// ---------------------------------------------------------------
	logic             ent_v;
	logic             ent_u;
	logic [PPN_W-1:0] ent_ppn;
	logic [PPN_W:0]   ptr_diff;
	logic             ptr_ok;
	logic [PAGE_W-1:0] ptr_page;

	assign ent_v    = rd_data[sv39tw_pkg::PTE_V_BIT];
	assign ent_u    = rd_data[sv39tw_pkg::PTE_U_BIT];
	assign ent_ppn  = rd_data[sv39tw_pkg::PTE_PPN_LSB +: PPN_W];
	// borrow in the top bit means the pointer is below the window
	assign ptr_diff = {1'b0, ent_ppn} - {1'b0, base_ppn_q};
	assign ptr_ok   = !ptr_diff[PPN_W] && (ptr_diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
	assign ptr_page = ptr_diff[PAGE_W-1:0];

	// ---------------------------------------------------------------
	// Walk sequencer
	// ---------------------------------------------------------------
	sv39tw_pkg::walk_state_t state_q, state_d;

	logic [IDX_W-1:0] idx1_q;  // VA[29:21]
	logic [IDX_W-1:0] idx0_q;  // VA[20:12]

	logic                          out_valid_q;
	logic [sv39tw_pkg::STATUS_W-1:0] status_q;
	logic [sv39tw_pkg::PA_W-1:0]   phys_q;

	logic                          out_free;
	logic                          in_fire;
	logic                          res_load;
	logic [sv39tw_pkg::STATUS_W-1:0] res_status;
	logic [sv39tw_pkg::PA_W-1:0]   res_pa;

	// A finished result can be loaded when the output register is empty
	// or its transfer completes this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sv39tw_pkg::WS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		res_load   = 1'b0;
		res_status = sv39tw_pkg::STATUS_OK;
		res_pa     = '0;

		unique case (state_q)
			sv39tw_pkg::WS_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (action == sv39tw_pkg::ACT_WRITE) begin
						wr_en = wpage_ok;
					end else if (root_ok) begin
						rd_en   = 1'b1;
						rd_addr = {root_ext[PAGE_W-1:0], virt_addr[38:30]};
						state_d = sv39tw_pkg::WS_L2;
					end else begin
						state_d = sv39tw_pkg::WS_ROOT_FAULT;
					end
				end
			end

			sv39tw_pkg::WS_ROOT_FAULT: begin
				if (out_free) begin
					res_load   = 1'b1;
					res_status = sv39tw_pkg::STATUS_OUTSIDE;
					state_d    = sv39tw_pkg::WS_IDLE;
				end
			end

			// Pointer levels; on a fault with the output busy, hold here
			// (read port idle, so the read data stays put).
			sv39tw_pkg::WS_L2, sv39tw_pkg::WS_L1: begin
				if (!ent_v) begin
					if (out_free) begin
						res_load   = 1'b1;
						res_status = sv39tw_pkg::STATUS_NOT_VALID;
						state_d    = sv39tw_pkg::WS_IDLE;
					end
				end else if (!ptr_ok) begin
					if (out_free) begin
						res_load   = 1'b1;
						res_status = sv39tw_pkg::STATUS_OUTSIDE;
						state_d    = sv39tw_pkg::WS_IDLE;
					end
				end else begin
					rd_en = 1'b1;
					if (state_q == sv39tw_pkg::WS_L2) begin
						rd_addr = {ptr_page, idx1_q};
						state_d = sv39tw_pkg::WS_L1;
					end else begin
						rd_addr = {ptr_page, idx0_q};
						state_d = sv39tw_pkg::WS_L0;
					end
				end
			end

			sv39tw_pkg::WS_L0: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d  = sv39tw_pkg::WS_IDLE;
					if (!ent_v) begin
						res_status = sv39tw_pkg::STATUS_NOT_VALID;
					end else if (!ent_u) begin
						res_status = sv39tw_pkg::STATUS_NOT_USER;
					end else begin
						res_pa = {ent_ppn, 12'd0};
					end
				end
			end

			default: state_d = sv39tw_pkg::WS_IDLE;
		endcase
	end

	// Lower VA indexes held for the later levels.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			idx1_q <= virt_addr[29:21];
			idx0_q <= virt_addr[20:12];
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			phys_q   <= res_pa;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign phys_addr = phys_q;

endmodule

### sv/sv39tw_ram.sv
module sv39tw_ram #(
	parameter int WIDTH  = 64,
	parameter int DEPTH  = 512,
	parameter int ADDR_W = 9
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### dv/sv39_translate_walk_unit_tb.sv
module sv39_translate_walk_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VA_W         = sv39tw_pkg::VA_W;
	localparam int EADDR_W      = sv39tw_pkg::EADDR_W;
	localparam int ENTRY_W      = sv39tw_pkg::ENTRY_W;
	localparam int PPN_W        = sv39tw_pkg::PPN_W;
	localparam int PA_W         = sv39tw_pkg::PA_W;
	localparam int IDX_W        = sv39tw_pkg::IDX_W;
	localparam int ROOT_W       = sv39tw_pkg::ROOT_W;
	localparam int STATUS_W     = sv39tw_pkg::STATUS_W;
	localparam int CFG_IDX_W    = sv39tw_pkg::CFG_IDX_W;
	localparam int CFG_W        = sv39tw_pkg::CFG_W;
	localparam int PTE_V_BIT    = sv39tw_pkg::PTE_V_BIT;
	localparam int PTE_U_BIT    = sv39tw_pkg::PTE_U_BIT;
	localparam int PTE_PPN_LSB  = sv39tw_pkg::PTE_PPN_LSB;

	localparam int PAGES        = sv39tw_pkg::TABLE_PAGES_DEF;
	localparam int PAGE_ENTRIES = 1 << IDX_W;
	localparam int ENTRIES      = PAGES * PAGE_ENTRIES;
	localparam int OFFSET_W     = 12;
	localparam int PHASE_ITEMS  = 200;
	localparam int N_PHASES     = 6;
	localparam int RECENT_DEPTH = 16;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [PPN_W-1:0] PPN_MAX = '1;

	// Indexes past the register list; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct {
		logic               action;
		logic [VA_W-1:0]    va;
		logic [EADDR_W-1:0] eaddr;
		logic [ENTRY_W-1:0] evalue;
	} walk_item_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [PA_W-1:0]     pa;
	} walk_result_t;

	// Where a generated pointer entry lands relative to the table window
	typedef enum int {PTR_GOOD, PTR_INVALID, PTR_BELOW, PTR_ABOVE} ptr_kind_t;

	// Output stall patterns, each held for a random stretch of cycles
	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 action      = sv39tw_pkg::ACT_WRITE;
	logic [VA_W-1:0]      virt_addr   = '0;
	logic [EADDR_W-1:0]   entry_addr  = '0;
	logic [ENTRY_W-1:0]   entry_value = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic [STATUS_W-1:0]  status;
	logic [PA_W-1:0]      phys_addr;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [CFG_W-1:0]     cfg_data    = '0;

	// Set at a rising edge when the driven item was taken
	logic                 in_taken    = 1'b0;

	sv39_translate_walk_unit #(
		.TABLE_PAGES(PAGES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.virt_addr(virt_addr),
		.entry_addr(entry_addr),
		.entry_value(entry_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.phys_addr(phys_addr),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Walker mirror: table contents and registers as the DUT sees them,
	// updated on accepted transfers only.
	// ---------------------------------------------------------------
	logic [ENTRY_W-1:0] tbl_mem [ENTRIES];
	logic [ROOT_W-1:0]  root_reg = '0;
	logic [PPN_W-1:0]   base_reg = '0;

	walk_result_t expected_results [$];

	// Stimulus-side shadow: runs ahead of the DUT by the queued items, and
	// tracks which entries hold data so no walk ever touches an unwritten word.
	logic [ENTRY_W-1:0] gen_mem [ENTRIES];
	bit                 gen_written [ENTRIES];
	logic [ROOT_W-1:0]  gen_root = '0;
	logic [PPN_W-1:0]   gen_base = '0;

	walk_item_t         pending_items [$];
	logic [VA_W-1:0]    recent_va [$];
	int                 items_queued = 0;

	int fail_count     = 0;
	int writes_done    = 0;
	int translates_done = 0;
	int cfg_writes     = 0;
	int status_seen [4];

	// Pointer entry -> table page inside the window; 0 if it falls outside
	function automatic bit window_page(input logic [ENTRY_W-1:0] ent,
		input logic [PPN_W-1:0] base, output int unsigned page);
		logic [PPN_W-1:0] ppn;
		ppn = ent[PTE_PPN_LSB +: PPN_W];
		page = 0;
		if (ppn < base || ppn - base >= PAGES)
			return 1'b0;
		page = int'(ppn - base);
		return 1'b1;
	endfunction

	// Three-level walk over the mirrored table, VPN[2] first
	function automatic walk_result_t predict_walk(input logic [VA_W-1:0] va);
		walk_result_t     r;
		logic [ENTRY_W-1:0] ent;
		int unsigned      page;
		int               lvl;
		r.status = sv39tw_pkg::STATUS_OK;
		r.pa = '0;
		page = 32'(root_reg);
		if (page >= PAGES) begin
			r.status = sv39tw_pkg::STATUS_OUTSIDE;
			return r;
		end
		for (lvl = 2; lvl >= 0; lvl--) begin
			ent = tbl_mem[page * PAGE_ENTRIES + va[OFFSET_W + IDX_W*lvl +: IDX_W]];
			if (!ent[PTE_V_BIT]) begin
				r.status = sv39tw_pkg::STATUS_NOT_VALID;
				return r;
			end
			if (lvl == 0) begin
				if (!ent[PTE_U_BIT]) begin
					r.status = sv39tw_pkg::STATUS_NOT_USER;
					return r;
				end
				r.pa = {ent[PTE_PPN_LSB +: PPN_W], {OFFSET_W{1'b0}}};
				return r;
			end
			if (!window_page(ent, base_reg, page)) begin
				r.status = sv39tw_pkg::STATUS_OUTSIDE;
				return r;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Clean pointer into the current window, nothing but V and the PPN set
	function automatic logic [ENTRY_W-1:0] ptr_to(input int unsigned page);
		logic [ENTRY_W-1:0] ent;
		ent = '0;
		ent[PTE_PPN_LSB +: PPN_W] = gen_base + page;
		ent[PTE_V_BIT] = 1'b1;
		return ent;
	endfunction

	// Pointer with random don't-care bits; the window edges get extra weight
	function automatic logic [ENTRY_W-1:0] make_pointer(input ptr_kind_t kind);
		logic [ENTRY_W-1:0] ent;
		logic [PPN_W-1:0]   ppn;
		logic [PPN_W-1:0]   span;
		ptr_kind_t          k;
		ent = rand64();
		k = kind;
		// no room below a window at zero, or above one at the top of the PPN range
		if (k == PTR_BELOW && gen_base == 0)
			k = PTR_ABOVE;
		if (k == PTR_ABOVE && PPN_MAX - gen_base < PAGES)
			k = PTR_BELOW;
		span = PPN_MAX - gen_base;
		case (k)
			PTR_GOOD: begin
				ppn = gen_base + $urandom_range(0, (span < PAGES) ? int'(span) : PAGES - 1);
			end
			PTR_BELOW: begin
				ppn = $urandom_range(0, 1) ? gen_base - 1 : PPN_W'(rand64() % gen_base);
			end
			PTR_ABOVE: begin
				span = PPN_MAX - gen_base - PAGES;
				ppn = PPN_W'(gen_base + PAGES +
					($urandom_range(0, 1) ? 64'd0 : rand64() % (span + 64'd1)));
			end
			default: ppn = PPN_W'(rand64());
		endcase
		ent[PTE_PPN_LSB +: PPN_W] = ppn;
		ent[PTE_V_BIT] = (k != PTR_INVALID);
		return ent;
	endfunction

	function automatic logic [ENTRY_W-1:0] make_leaf();
		logic [ENTRY_W-1:0] ent;
		ent = rand64();
		ent[PTE_V_BIT] = ($urandom_range(0, 9) != 0);
		ent[PTE_U_BIT] = ($urandom_range(0, 4) != 0);
		return ent;
	endfunction

	function automatic ptr_kind_t pick_kind(input bit mostly_good);
		int r;
		if (!mostly_good)
			return ptr_kind_t'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		if (r < 88)
			return PTR_GOOD;
		if (r < 92)
			return PTR_INVALID;
		if (r < 96)
			return PTR_BELOW;
		return PTR_ABOVE;
	endfunction

	task automatic queue_write(input int unsigned addr, input logic [ENTRY_W-1:0] value);
		walk_item_t it;
		it.action = sv39tw_pkg::ACT_WRITE;
		it.va = VA_W'(rand64());
		it.eaddr = EADDR_W'(addr);
		it.evalue = value;
		gen_mem[addr] = value;
		gen_written[addr] = 1'b1;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic queue_translate(input logic [VA_W-1:0] va);
		walk_item_t it;
		it.action = sv39tw_pkg::ACT_TRANSLATE;
		it.va = va;
		it.eaddr = EADDR_W'($urandom);
		it.evalue = rand64();
		pending_items.push_back(it);
		items_queued++;
		recent_va.push_back(va);
		if (recent_va.size() > RECENT_DEPTH)
			void'(recent_va.pop_front());
	endtask

	// Walk va through the shadow tables, writing any entry the walk will read
	// that holds no data yet (all of them when fresh), then translate it.
	task automatic walk_with_tables(input logic [VA_W-1:0] va, input bit fresh);
		int unsigned        page;
		int unsigned        addr;
		int                 lvl;
		logic [ENTRY_W-1:0] ent;
		page = 32'(gen_root);
		for (lvl = 2; lvl >= 0; lvl--) begin
			addr = page * PAGE_ENTRIES + va[OFFSET_W + IDX_W*lvl +: IDX_W];
			if (fresh || !gen_written[addr])
				queue_write(addr, (lvl == 0) ? make_leaf() : make_pointer(pick_kind(fresh)));
			ent = gen_mem[addr];
			if (!ent[PTE_V_BIT])
				break;
			if (lvl > 0 && !window_page(ent, gen_base, page))
				break;
		end
		queue_translate(va);
	endtask

	// Mostly fresh, well-formed mappings; then revisits of recent pages over
	// stale tables, walks through whatever is there, and stray writes.
	task automatic fill_random(input int n);
		int              target;
		int              r;
		logic [VA_W-1:0] va;
		target = items_queued + n;
		while (items_queued < target) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				walk_with_tables(VA_W'(rand64()), 1'b1);
			end else if (r < 80 && recent_va.size() > 0) begin
				va = recent_va[$urandom_range(0, recent_va.size() - 1)];
				va[OFFSET_W-1:0] = OFFSET_W'($urandom);
				walk_with_tables(va, 1'b0);
			end else if (r < 92) begin
				walk_with_tables(VA_W'(rand64()), 1'b0);
			end else begin
				queue_write($urandom_range(0, ENTRIES - 1), rand64());
			end
		end
	endtask

	// One register transfer; cfg_valid stays high so back-to-back writes
	// never lower and raise it in the same step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic configure_phase(input logic [ROOT_W-1:0] root, input logic [PPN_W-1:0] base);
		logic [CFG_W-1:0] junk;
		gen_root = root;
		gen_base = base;
		junk = CFG_W'(rand64());
		// bits above the root field ride along and must be dropped
		if ($urandom_range(0, 1)) begin
			write_reg(sv39tw_pkg::REG_ROOT_TABLE_PAGE, {junk[CFG_W-1:ROOT_W], root});
			write_reg(sv39tw_pkg::REG_TABLE_BASE_PPN, base);
		end else begin
			write_reg(sv39tw_pkg::REG_TABLE_BASE_PPN, base);
			write_reg(sv39tw_pkg::REG_ROOT_TABLE_PAGE, {junk[CFG_W-1:ROOT_W], root});
		end
		write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'(rand64()));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Idle means nothing queued, nothing on the input, nothing outstanding;
	// then a drain wait so a trailing table write has landed
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// Driver: input items in bursts with gaps, output stall on its own
	// pattern. Everything changes at the falling edge.
	// ---------------------------------------------------------------
	int          burst_left  = 1;
	int          gap_left    = 0;
	int          stall_hold  = 0;
	int          tick        = 0;
	stall_mode_t stall_mode  = STALL_NONE;

	always @(negedge clk) begin
		walk_item_t it;
		if (arst_n) begin
			tick++;
			if (stall_hold == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				stall_hold = $urandom_range(20, 200);
			end else begin
				stall_hold--;
			end
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
				STALL_PERIODIC: out_stall <= (tick % 5 < 2);
				default:        out_stall <= ($urandom_range(0, 7) != 0);
			endcase

			// a stalled transfer holds its payload untouched
			if (!in_valid || in_taken) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					it = pending_items.pop_front();
					action      <= it.action;
					virt_addr   <= it.va;
					entry_addr  <= it.eaddr;
					entry_value <= it.evalue;
					in_valid    <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: checks results against the oldest expectation first, then
	// folds in this edge's input and register transfers.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		walk_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: status %0d phys_addr 0x%h", status, phys_addr);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, status);
						fail_count++;
					end
					if (phys_addr !== want.pa) begin
						$error("phys_addr: expected 0x%h, actual 0x%h", want.pa, phys_addr);
						fail_count++;
					end
					status_seen[want.status]++;
				end
			end

			if (in_valid && !in_stall) begin
				if (action == sv39tw_pkg::ACT_WRITE) begin
					if ((entry_addr >> IDX_W) < PAGES)
						tbl_mem[entry_addr] = entry_value;
					writes_done++;
				end else begin
					expected_results.push_back(predict_walk(virt_addr));
					translates_done++;
				end
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sv39tw_pkg::REG_ROOT_TABLE_PAGE: root_reg = cfg_data[ROOT_W-1:0];
					sv39tw_pkg::REG_TABLE_BASE_PPN:  base_reg = cfg_data;
					default: ;
				endcase
				cfg_writes++;
			end
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	// ---------------------------------------------------------------
	// Sequence: reset, then phases of register settings, each filled with
	// stimulus and drained before the next register write.
	// ---------------------------------------------------------------
	initial begin
		int                ph;
		logic [ROOT_W-1:0] root;
		logic [PPN_W-1:0]  base;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Phase 0: root page 0, window at PPN 0
		configure_phase('0, '0);

		// root[0] -> page 1, page 1 [0] -> last page, leaf with every bit set
		queue_write(0, ptr_to(1));
		queue_write(PAGE_ENTRIES, ptr_to(PAGES - 1));
		queue_write((PAGES - 1) * PAGE_ENTRIES, '1);
		queue_translate('0);
		// valid leaf lacking the user bit, offset bits all ones
		queue_write((PAGES - 1) * PAGE_ENTRIES + PAGE_ENTRIES - 1, ptr_to(1));
		queue_translate(39'h1F_FFFF);
		// same slot via the highest entry address, now a good leaf
		queue_write(ENTRIES - 1, '1);
		queue_translate(39'h1F_FFFF);
		// leaf with everything but the valid bit
		queue_write((PAGES - 1) * PAGE_ENTRIES + 5, ~64'd1);
		queue_translate(39'h5000);
		// invalid middle-level entry
		queue_write(PAGE_ENTRIES + PAGE_ENTRIES - 1, '0);
		queue_translate(39'h3FE0_0000);
		// root pointer one page past the window, reached by the all-ones address
		queue_write(PAGE_ENTRIES - 1, ptr_to(PAGES));
		queue_translate('1);
		// invalid root entries
		queue_write(1, '0);
		queue_translate(39'h4000_0000);
		queue_write(0, '0);
		queue_translate('0);

		fill_random(PHASE_ITEMS);
		wait_idle();

		for (ph = 1; ph < N_PHASES; ph++) begin
			case (ph)
				// both registers at their maximum: only page 0 is in the window
				1: begin
					root = '1;
					base = PPN_MAX;
				end
				// window ends exactly at the top PPN
				2: begin
					root = ROOT_W'($urandom);
					base = PPN_MAX - (PAGES - 1);
				end
				// small nonzero base: pointers just below the window are easy to hit
				3: begin
					root = ROOT_W'($urandom);
					base = PPN_W'($urandom_range(1, 300));
				end
				default: begin
					root = ROOT_W'($urandom);
					base = PPN_W'(rand64());
				end
			endcase
			configure_phase(root, base);
			fill_random(PHASE_ITEMS);
			wait_idle();
		end

		$display("covered %0d table writes and %0d translations over %0d register writes",
			writes_done, translates_done, cfg_writes);
		$display("outcomes: %0d mapped, %0d invalid entry, %0d no user bit, %0d outside window",
			status_seen[sv39tw_pkg::STATUS_OK], status_seen[sv39tw_pkg::STATUS_NOT_VALID],
			status_seen[sv39tw_pkg::STATUS_NOT_USER], status_seen[sv39tw_pkg::STATUS_OUTSIDE]);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin
		#10ms;
		$display("simulation failed");
		$finish;
	end

endmodule
